// ===== design/plrs_pkg.sv =====
// Package for the pooled LCG random source.
// Holds the request codes, arithmetic constants and the shared-unit control types.
// No dependencies.
`default_nettype none

package plrs_pkg;

   localparam int DEFAULT_POOL_DEPTH = 256;

   // Request operation codes.
   localparam logic [1:0] OP_DRAW31 = 2'd0;
   localparam logic [1:0] OP_FRAC   = 2'd1;
   localparam logic [1:0] OP_WORD   = 2'd2;

   // First-use cubic offsets and the LCG step.
   localparam logic [31:0] CUBE_OFS_A = 32'd115;
   localparam logic [31:0] CUBE_OFS_B = 32'd123;
   localparam logic [31:0] CUBE_OFS_C = 32'd17;
   localparam logic [31:0] LCG_MULT   = 32'd1103515245;
   localparam logic [31:0] LCG_INC    = 32'd12345;

   localparam int FRAC_SHIFT = 8;
   localparam int WORD_SHIFT = 15;

   // Shared arithmetic unit modes.
   typedef logic [1:0] alu_mode_type;
   localparam alu_mode_type ALU_HOLD = 2'd0;
   localparam alu_mode_type ALU_MUL  = 2'd1;
   localparam alu_mode_type ALU_ADD  = 2'd2;

   typedef struct packed {
      alu_mode_type mode;
      logic [31:0]  opa;
      logic [31:0]  opb;
   } alu_req_type;

endpackage

`default_nettype wire

// ===== design/plrs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module plrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/plrs_alu.sv =====
// Shared 32-bit multiply/add unit with its accumulator register.
// Depends on plrs_pkg for the request struct and mode codes.
`default_nettype none

module plrs_alu import plrs_pkg::*; (
   input  wire logic        clock,
   input  wire alu_req_type alu_req,
   output logic [31:0]      acc
);

   logic [31:0] acc_ff;
   logic [31:0] acc_in;

   // All arithmetic wraps modulo 2^32, so only the low product word is kept.
   always_comb begin
      case (alu_req.mode)
         ALU_MUL: acc_in = 32'(alu_req.opa * alu_req.opb);
         ALU_ADD: acc_in = alu_req.opa + alu_req.opb;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== design/pooled_lcg_random_source.sv =====
// Channel   Ports                                   Direction
// req       req_valid/req_ready, operation, tag     in
// rsp       rsp_valid/rsp_ready, value              out
// csr       csr_wen, csr_wdata (seed)               in
//
// One beat is taken in the idle cycle; each draw then runs READ, LOAD, LCG and DONE
// on a used pool entry, adding CUBE and TAG on first use (a RAM read plus the chain of
// dependent multiplies through the one shared multiplier). A 32-bit word needs two draws.
// Reset is synchronous; it clears the seed, the pool pointer and the pool-used mark.
// A finished result waits in the output register while the next beat is taken; the
// sequencer only stalls when it has a new result and that register is still full.
// Depends on plrs_pkg, plrs_ram and plrs_alu.
`default_nettype none

module pooled_lcg_random_source import plrs_pkg::*; #(
   parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic signed [31:0] req_tag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_value,
   input  wire logic        csr_wen,
   input  wire logic [31:0] csr_wdata
);

   localparam int PW = $clog2(POOL_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(POOL_DEPTH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_CUBE = 3'd3;
   localparam logic [2:0] ST_TAG  = 3'd4;
   localparam logic [2:0] ST_LCG  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic          wrapped_ff, wrapped_in;
   logic [31:0]   seed_ff, seed_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   tag_ff, tag_in;
   logic [31:0]   base_ff, base_in;
   logic [30:0]   first_ff, first_in;
   logic          second_ff, second_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;

   alu_req_type   alu_req;
   logic [31:0]   acc;
   logic [30:0]   pool_rdata;
   logic          ram_rd_en;
   logic          ram_wr_en;
   logic [30:0]   draw;
   logic [31:0]   result;
   logic          last_draw;
   logic          out_free;
   logic          done_go;
   logic          req_take;

   plrs_ram #(
      .WIDTH (31),
      .DEPTH (POOL_DEPTH)
   ) u_pool (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (draw),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (pool_rdata)
   );

   plrs_alu u_alu (
      .clock   (clock),
      .alu_req (alu_req),
      .acc     (acc)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // The stored entry drops its used bit; used entries are told apart by the
   // pointer having wrapped since the last clear, since claims go in order.
   assign draw      = 31'(acc + LCG_INC);
   assign last_draw = (op_ff != OP_WORD) || second_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done_go   = (state_ff == ST_DONE) && (!last_draw || out_free);
   assign ram_rd_en = (state_ff == ST_READ);
   assign ram_wr_en = done_go && !csr_wen;

   always_comb begin
      case (op_ff)
         OP_FRAC: result = 32'(draw >> FRAC_SHIFT);
         OP_WORD: result = {first_ff, 1'b0} ^ 32'(draw >> WORD_SHIFT);
         default: result = {1'b0, draw};
      endcase
   end

   always_comb begin
      alu_req.mode = ALU_HOLD;
      alu_req.opa  = acc;
      alu_req.opb  = tag_ff;
      case (state_ff)
         ST_LOAD: begin
            if (wrapped_ff) begin
               alu_req.mode = ALU_ADD;
               alu_req.opa  = {1'b0, pool_rdata};
               alu_req.opb  = tag_ff;
            end else begin
               alu_req.mode = ALU_MUL;
               alu_req.opa  = 32'(ptr_ff) + CUBE_OFS_A;
               alu_req.opb  = 32'(ptr_ff) + CUBE_OFS_B;
            end
         end
         ST_CUBE: begin
            alu_req.mode = ALU_MUL;
            alu_req.opb  = base_ff;
         end
         ST_TAG: begin
            alu_req.mode = ALU_ADD;
         end
         ST_LCG: begin
            alu_req.mode = ALU_MUL;
            alu_req.opb  = LCG_MULT;
         end
         default: begin
            alu_req.mode = ALU_HOLD;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      wrapped_in   = wrapped_ff;
      seed_in      = seed_ff;
      op_in        = op_ff;
      tag_in       = tag_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in     = req_operation;
               tag_in    = req_tag;
               second_in = 1'b0;
               // An unknown operation is taken and dropped without a result.
               if (req_operation == OP_DRAW31 || req_operation == OP_FRAC ||
                   req_operation == OP_WORD) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            base_in  = seed_ff + 32'(ptr_ff) + CUBE_OFS_C;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = wrapped_ff ? ST_LCG : ST_CUBE;
         end
         ST_CUBE: begin
            state_in = ST_TAG;
         end
         ST_TAG: begin
            state_in = ST_LCG;
         end
         ST_LCG: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (done_go) begin
               if (ptr_ff == PTR_LAST) begin
                  ptr_in     = '0;
                  wrapped_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + PW'(1);
               end
               if (last_draw) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = result;
                  state_in     = ST_IDLE;
               end else begin
                  first_in  = draw;
                  second_in = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A seed write restarts the pool from scratch.
      if (csr_wen) begin
         seed_in    = csr_wdata;
         ptr_in     = '0;
         wrapped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         wrapped_ff   <= 1'b0;
         seed_ff      <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wrapped_ff   <= wrapped_in;
         seed_ff      <= seed_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tag_ff       <= tag_in;
      base_ff      <= base_in;
      first_ff     <= first_in;
      rsp_value_ff <= rsp_value_in;
   end

   // A valid request always starts with a pool read.
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_operation == OP_DRAW31 || req_operation == OP_FRAC ||
                    req_operation == OP_WORD)) |=> (state_ff == ST_READ))
      else $error("valid request did not start a pool read");

   // Each finished draw that meets no seed write advances the pointer by exactly one entry.
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (done_go && !csr_wen) |=>
         (ptr_ff == (($past(ptr_ff) == PTR_LAST) ? '0 : $past(ptr_ff) + PW'(1))))
      else $error("pool pointer did not advance by one");

   // The used mark only drops on reset or a seed write.
   a_wrap_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(wrapped_ff) |-> ($past(csr_wen) || $past(reset)))
      else $error("pool used mark cleared without a seed write");

   // A new result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_value_ff))
      else $error("pending result was overwritten");

endmodule

`default_nettype wire
